// ===== rtl/akss_pkg.sv =====
`default_nettype none
package akss_pkg;

	localparam int unsigned N_KEYS  = 90;
	localparam int unsigned N_STEPS = 7;
	localparam int unsigned N_LANES = 4;

	localparam logic [14:0] CENTER_RADIUS = 15'd32766;
	localparam logic [7:0]  FULL_SCALE    = 8'd255;
	localparam logic [6:0]  OFF_RIGHT     = 7'd90;
	localparam logic [6:0]  KEY_LIMIT     = 7'd90;
	localparam logic signed [9:0] WRITE_MIN = 10'sd45;
	localparam logic signed [9:0] WRITE_MAX = 10'sd150;
	localparam logic signed [9:0] ANGLE_MAX = 10'sd180;

	localparam logic [31:0] RST_CENTER  = 32'd1733975906;
	localparam logic [14:0] RST_RAD_MAX = 15'd4000;
	localparam logic [14:0] RST_RAD_MIN = 15'd700;
	localparam logic [11:0] RST_FRONT   = 12'd300;
	localparam logic [11:0] RST_BACK    = 12'd300;
	localparam logic [11:0] RST_TRACK   = 12'd200;
	localparam logic [7:0]  RST_DEAD    = 8'd20;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef enum logic [2:0] {
		REG_CENTER   = 3'd0,
		REG_RAD_MAX  = 3'd1,
		REG_RAD_MIN  = 3'd2,
		REG_FRONT    = 3'd3,
		REG_BACK     = 3'd4,
		REG_TRACK    = 3'd5,
		REG_DEADBAND = 3'd6
	} reg_idx_t;

	typedef logic [30:0] tab_t [N_KEYS];

	typedef struct packed {
		logic [11:0] span;
		logic [15:0] den;
		logic        nonpos;
		logic [6:0]  cnt;
	} srch_t;

	typedef struct packed {
		logic        centered;
		logic        left;
		logic [14:0] radius;
	} side_t;

	function automatic tab_t build_tab(input logic want_cos);
		tab_t t;
		longint unsigned a;
		longint unsigned x2;
		longint unsigned ts;
		longint unsigned tc;
		longint ss;
		longint sc;
		for (int k = 0; k < N_KEYS; k++) begin
			a  = (longint'(2 * k + 1) * PI_Q30) / 360;
			x2 = (a * a) >> 30;
			ts = a;
			tc = ONE_Q30;
			ss = longint'(a);
			sc = longint'(ONE_Q30);
			ts = ((ts * x2) >> 30) / 6;   tc = ((tc * x2) >> 30) / 2;
			ss = ss - longint'(ts);       sc = sc - longint'(tc);
			ts = ((ts * x2) >> 30) / 20;  tc = ((tc * x2) >> 30) / 12;
			ss = ss + longint'(ts);       sc = sc + longint'(tc);
			ts = ((ts * x2) >> 30) / 42;  tc = ((tc * x2) >> 30) / 30;
			ss = ss - longint'(ts);       sc = sc - longint'(tc);
			ts = ((ts * x2) >> 30) / 72;  tc = ((tc * x2) >> 30) / 56;
			ss = ss + longint'(ts);       sc = sc + longint'(tc);
			ts = ((ts * x2) >> 30) / 110; tc = ((tc * x2) >> 30) / 90;
			ss = ss - longint'(ts);       sc = sc - longint'(tc);
			ts = ((ts * x2) >> 30) / 156; tc = ((tc * x2) >> 30) / 132;
			ss = ss + longint'(ts);       sc = sc + longint'(tc);
			ts = ((ts * x2) >> 30) / 210; tc = ((tc * x2) >> 30) / 182;
			ss = ss - longint'(ts);       sc = sc - longint'(tc);
			ts = ((ts * x2) >> 30) / 272; tc = ((tc * x2) >> 30) / 240;
			ss = ss + longint'(ts);       sc = sc + longint'(tc);
			if (want_cos) begin
				t[k] = (sc > 0) ? sc[30:0] : '0;
			end else begin
				t[k] = (ss > 0) ? ss[30:0] : '0;
			end
		end
		return t;
	endfunction

	localparam tab_t SIN_TAB = build_tab(1'b0);
	localparam tab_t COS_TAB = build_tab(1'b1);

endpackage
`default_nettype wire

// ===== rtl/akss_in_if.sv =====
`default_nettype none
interface akss_in_if;
	logic             valid;
	logic             ready;
	logic signed [8:0] joystick;

	modport source (output valid, output joystick, input ready);
	modport sink (input valid, input joystick, output ready);
endinterface
`default_nettype wire

// ===== rtl/akss_out_if.sv =====
`default_nettype none
interface akss_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  angle_one;
	logic [7:0]  angle_two;
	logic [7:0]  angle_three;
	logic [7:0]  angle_four;
	logic        write_one;
	logic        write_two;
	logic        write_three;
	logic        write_four;
	logic [14:0] turn_radius;
	logic        turning_left;

	modport source (output valid, output angle_one, output angle_two, output angle_three,
		output angle_four, output write_one, output write_two, output write_three,
		output write_four, output turn_radius, output turning_left, input ready);
	modport sink (input valid, input angle_one, input angle_two, input angle_three,
		input angle_four, input write_one, input write_two, input write_three,
		input write_four, input turn_radius, input turning_left, output ready);
endinterface
`default_nettype wire

// ===== rtl/akss_cell.sv =====
`default_nettype none
module akss_cell (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [2:0]     step,
	input  wire akss_pkg::srch_t d_in,
	output      akss_pkg::srch_t d_out
);
	import akss_pkg::*;

	logic [6:0]  probe;
	logic [6:0]  idx;
	logic        in_range;
	logic [30:0] cos_v;
	logic [30:0] sin_v;
	logic [47:0] lhs;
	logic [47:0] rhs;
	logic        take;
	srch_t       d_q;

	always_comb begin
		probe    = d_in.cnt | (7'd1 << step);
		idx      = probe - 7'd1;
		in_range = (probe <= KEY_LIMIT);
		cos_v    = in_range ? COS_TAB[idx] : '0;
		sin_v    = in_range ? SIN_TAB[idx] : '0;
		lhs      = {5'd0, 43'(d_in.span * cos_v)};
		rhs      = {1'b0, 47'(d_in.den * sin_v)};
		take     = in_range && (lhs >= rhs);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q.span   <= d_in.span;
			d_q.den    <= d_in.den;
			d_q.nonpos <= d_in.nonpos;
			d_q.cnt    <= take ? probe : d_in.cnt;
		end
	end

	assign d_out = d_q;
endmodule
`default_nettype wire

// ===== rtl/ackermann_steering_servo_angles.sv =====
`default_nettype none
// Steering joystick to four wheel servo angles.
// joy: one signed joystick beat in; servo: one beat out per input beat with
// four angles, their write flags, the turning radius and the direction.
// Configuration: wr_en, wr_index, wr_data write one register per cycle;
// write only while no beat is in flight.
// An accepted input beat passes three radius stages, seven atan search cells
// and one output register before it leaves as a valid output beat.
// Throughput: one beat per cycle while servo.ready stays high; each search cell
// resolves one bit of the whole-degree angle, so the seven-cell row sets the depth.
// Stall: every stage advances when it is empty or its successor advances;
// with servo.ready low the pipeline fills and then joy.ready drops.
// Bubbles inside the pipeline are squeezed out under stall.
// Reset: all stages empty, registers at their defaults, joy.ready high.
module ackermann_steering_servo_angles (
	input  wire logic        clk,
	input  wire logic        arst_n,
	akss_in_if.sink          joy,
	akss_out_if.source       servo,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [31:0] wr_data
);
	import akss_pkg::*;

	logic [31:0] center_q;
	logic [14:0] rad_max_q;
	logic [14:0] rad_min_q;
	logic [11:0] front_q;
	logic [11:0] back_q;
	logic [11:0] track_q;
	logic [7:0]  dead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q  <= RST_CENTER;
			rad_max_q <= RST_RAD_MAX;
			rad_min_q <= RST_RAD_MIN;
			front_q   <= RST_FRONT;
			back_q    <= RST_BACK;
			track_q   <= RST_TRACK;
			dead_q    <= RST_DEAD;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_CENTER:   center_q  <= wr_data;
				REG_RAD_MAX:  rad_max_q <= wr_data[14:0];
				REG_RAD_MIN:  rad_min_q <= wr_data[14:0];
				REG_FRONT:    front_q   <= wr_data[11:0];
				REG_BACK:     back_q    <= wr_data[11:0];
				REG_TRACK:    track_q   <= wr_data[11:0];
				REG_DEADBAND: dead_q    <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3, out_v_q;
	logic en_s1, en_s2, en_s3, en_out;
	logic [N_STEPS-1:0] cv_s;
	logic [N_STEPS-1:0] en_c;

	assign en_out = !out_v_q | servo.ready;
	assign en_s3  = !v_s3 | en_c[0];
	assign en_s2  = !v_s2 | en_s3;
	assign en_s1  = !v_s1 | en_s2;
	assign joy.ready = en_s1;

	for (genvar i = 0; i < N_STEPS; i++) begin : g_en
		if (i == N_STEPS - 1) begin : g_last
			assign en_c[i] = !cv_s[i] | en_out;
		end else begin : g_mid
			assign en_c[i] = !cv_s[i] | en_c[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			cv_s    <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= joy.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_c[0]) cv_s[0] <= v_s3;
			for (int i = 1; i < N_STEPS; i++) begin
				if (en_c[i]) cv_s[i] <= cv_s[i-1];
			end
			if (en_out) out_v_q <= cv_s[N_STEPS-1];
		end
	end

	// stage 1: magnitude, deadband, slope product
	logic [8:0]  mag;
	logic [7:0]  mag_sat;
	logic        neg_slope;
	logic [14:0] slope;
	logic        centered;

	always_comb begin
		mag       = joy.joystick[8] ? 9'(-joy.joystick) : joy.joystick;
		mag_sat   = mag[8] ? FULL_SCALE : mag[7:0];
		neg_slope = rad_min_q < rad_max_q;
		slope     = neg_slope ? rad_max_q - rad_min_q : rad_min_q - rad_max_q;
		centered  = mag <= {1'b0, dead_q};
	end

	logic [22:0] prod_s1;
	logic        neg_s1;
	logic        cen_s1;
	logic        left_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= 23'(mag_sat * slope);
			neg_s1  <= neg_slope;
			cen_s1  <= centered;
			left_s1 <= joy.joystick[8] & !centered;
		end
	end

	// stage 2: quotient estimate, floor(p/255) or one below
	logic [30:0] prod_x;
	logic [14:0] quo_s2;
	logic [22:0] prod_s2;
	logic        neg_s2;
	logic        cen_s2;
	logic        left_s2;

	assign prod_x = {prod_s1, 8'd0} + {8'd0, prod_s1};

	always_ff @(posedge clk) begin
		if (en_s2) begin
			quo_s2  <= prod_x[30:16];
			prod_s2 <= prod_s1;
			neg_s2  <= neg_s1;
			cen_s2  <= cen_s1;
			left_s2 <= left_s1;
		end
	end

	// stage 3: correct quotient, form radius
	logic [23:0] rem;
	logic [14:0] quo;
	logic [14:0] radius;

	always_comb begin
		rem    = {1'b0, prod_s2} - ({1'b0, quo_s2, 8'd0} - {9'd0, quo_s2});
		quo    = (rem >= {16'd0, FULL_SCALE}) ? quo_s2 + 15'd1 : quo_s2;
		radius = neg_s2 ? rad_max_q - quo : rad_max_q + quo;
		if (cen_s2) radius = CENTER_RADIUS;
	end

	side_t side_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			side_s3.centered <= cen_s2;
			side_s3.left     <= left_s2;
			side_s3.radius   <= radius;
		end
	end

	// search row: lanes are outer front, outer back, inner front, inner back
	logic [15:0]        den_out;
	logic signed [16:0] den_in;
	srch_t              seed [N_LANES];

	always_comb begin
		den_out = {1'b0, side_s3.radius} + {4'd0, track_q};
		den_in  = $signed({2'b0, side_s3.radius}) - $signed({5'b0, track_q});
		seed[0] = '{span: front_q, den: den_out, nonpos: den_out == '0, cnt: '0};
		seed[1] = '{span: back_q, den: den_out, nonpos: den_out == '0, cnt: '0};
		seed[2] = '{span: front_q, den: den_in[15:0],
			nonpos: den_in[16] || den_in == '0, cnt: '0};
		seed[3] = '{span: back_q, den: den_in[15:0],
			nonpos: den_in[16] || den_in == '0, cnt: '0};
	end

	srch_t link [N_LANES][N_STEPS+1];

	for (genvar l = 0; l < N_LANES; l++) begin : g_lane
		assign link[l][0] = seed[l];
		for (genvar s = 0; s < N_STEPS; s++) begin : g_cell
			akss_cell u_cell (
				.clk   (clk),
				.en    (en_c[s]),
				.step  (3'(N_STEPS - 1 - s)),
				.d_in  (link[l][s]),
				.d_out (link[l][s+1])
			);
		end
	end

	side_t side_s [N_STEPS];

	always_ff @(posedge clk) begin
		if (en_c[0]) side_s[0] <= side_s3;
		for (int i = 1; i < N_STEPS; i++) begin
			if (en_c[i]) side_s[i] <= side_s[i-1];
		end
	end

	// output stage
	logic [6:0]        off [N_LANES];
	logic signed [9:0] ang [N_LANES];
	logic signed [9:0] cen [N_LANES];
	side_t             last;

	always_comb begin
		last = side_s[N_STEPS-1];
		for (int l = 0; l < N_LANES; l++) begin
			off[l] = link[l][N_STEPS].nonpos ? OFF_RIGHT : link[l][N_STEPS].cnt;
			if (last.centered) off[l] = '0;
			cen[l] = $signed({2'b0, center_q[8*l +: 8]});
		end
		if (last.left) begin
			ang[0] = cen[0] - $signed({3'b0, off[0]});
			ang[1] = cen[1] + $signed({3'b0, off[1]});
			ang[2] = cen[2] - $signed({3'b0, off[2]});
			ang[3] = cen[3] + $signed({3'b0, off[3]});
		end else begin
			ang[0] = cen[0] + $signed({3'b0, off[2]});
			ang[1] = cen[1] - $signed({3'b0, off[3]});
			ang[2] = cen[2] + $signed({3'b0, off[0]});
			ang[3] = cen[3] - $signed({3'b0, off[1]});
		end
	end

	logic [7:0]         angle_q [N_LANES];
	logic [N_LANES-1:0] write_q;
	logic [14:0]        radius_q;
	logic               left_q;

	always_ff @(posedge clk) begin
		if (en_out) begin
			for (int l = 0; l < N_LANES; l++) begin
				if (ang[l] < 0) begin
					angle_q[l] <= '0;
				end else if (ang[l] > ANGLE_MAX) begin
					angle_q[l] <= ANGLE_MAX[7:0];
				end else begin
					angle_q[l] <= ang[l][7:0];
				end
				write_q[l] <= (ang[l] > WRITE_MIN) && (ang[l] < WRITE_MAX);
			end
			radius_q <= last.radius;
			left_q   <= last.left;
		end
	end

	assign servo.valid        = out_v_q;
	assign servo.angle_one    = angle_q[0];
	assign servo.angle_two    = angle_q[1];
	assign servo.angle_three  = angle_q[2];
	assign servo.angle_four   = angle_q[3];
	assign servo.write_one    = write_q[0];
	assign servo.write_two    = write_q[1];
	assign servo.write_three  = write_q[2];
	assign servo.write_four   = write_q[3];
	assign servo.turn_radius  = radius_q;
	assign servo.turning_left = left_q;

`ifndef NO_ASSERTIONS
	a_centre_not_left: assert property (@(posedge clk) disable iff (!arst_n)
		servo.valid && servo.turn_radius == CENTER_RADIUS |-> !servo.turning_left)
		else $error("centred beat flagged as left turn");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		servo.valid && servo.write_one |->
		servo.angle_one > 8'd45 && servo.angle_one < 8'd150)
		else $error("write flag set outside angle window");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		joy.valid && joy.ready |=> v_s1)
		else $error("accepted beat lost at first stage");
`endif
endmodule
`default_nettype wire
